// ===== sv/ppte_pkg.sv =====
// Shared constants and types for the piecewise polynomial trajectory evaluator.
`default_nettype none
package ppte_pkg;
    localparam int MaxPieces = 32;
    localparam int PolyOrder = 8;
    localparam int Slots = 8;
    localparam int Axes = 3;
    localparam int FracBits = 24;
    localparam int PieceW = $clog2(MaxPieces);
    localparam int CountW = $clog2(MaxPieces + 1);
    localparam int SlotW = 3;
    localparam int CoefDepth = MaxPieces * Axes * Slots;
    localparam int CoefAddrW = $clog2(CoefDepth);

    localparam logic [1:0] KIND_COEF = 2'd0;
    localparam logic [1:0] KIND_DUR = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    localparam logic [27:0] LEAD_RESET = 28'd4026532;

    localparam logic signed [47:0] MAX48 = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] MIN48 = {1'b1, {47{1'b0}}};

    // Coefficient word address: (piece*3 + axis)*8 + slot.
    function automatic logic [CoefAddrW-1:0] coef_addr(input logic [PieceW-1:0] p,
                                                      input logic [1:0] a,
                                                      input logic [SlotW-1:0] s);
        logic [CoefAddrW+1:0] r;
        r = ((CoefAddrW + 2)'(p) * (CoefAddrW + 2)'(Axes) + (CoefAddrW + 2)'(a))
            * (CoefAddrW + 2)'(Slots) + (CoefAddrW + 2)'(s);
        return r[CoefAddrW-1:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [49:0] x);
        if (x > 50'sd140737488355327) return MAX48;
        if (x < -50'sd140737488355328) return MIN48;
        return x[47:0];
    endfunction
endpackage
`default_nettype wire

// ===== sv/ppte_mac.sv =====
// Multi-cycle Horner step: round(acc*t/2^24) saturated, plus coefficient, saturated.
`default_nettype none
module ppte_mac (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [47:0] acc,
    input  wire logic signed [33:0] t,
    input  wire logic signed [47:0] coef,
    output logic                    done,
    output logic signed [47:0]      result
);
    // Magnitudes: |acc|<=2^47 (48 bits), |t|<2^34. Product split into
    // acc_mag = ah*2^24 + al, four 24x34 partial products would exceed need;
    // use two 24x34 products, one in PH_LO and one in PH_HI.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LO   = 2'd1;
    localparam logic [1:0] PH_HI   = 2'd2;
    localparam logic [1:0] PH_SUM  = 2'd3;
    localparam int FracBitsL = ppte_pkg::FracBits;

    logic [1:0]  phase_reg, phase_next;
    logic        neg_reg;
    logic [47:0] ma_reg;
    logic [33:0] mb_reg;
    logic [57:0] plo_reg;
    logic [57:0] phi_reg;
    logic signed [47:0] coef_reg;
    logic signed [47:0] result_reg;
    logic        done_reg;

    logic [47:0] ma_c;
    logic [33:0] mb_c;
    logic [57:0] prod_c;
    logic [23:0] mul_a;
    logic [47:0] limit;
    logic [47:0] mag;
    logic signed [49:0] sum;
    logic signed [47:0] prod_s;

    assign ma_c = acc[47] ? 48'(-acc) : acc;
    assign mb_c = t[33] ? 34'(-t) : t;
    assign mul_a = (phase_reg == PH_LO) ? ma_reg[23:0] : ma_reg[47:24];
    assign prod_c = 58'(mul_a) * 58'(mb_reg);
    assign limit = neg_reg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;

    // hi*mb + ((lo*mb + 2^23) >> 24); no overflow of 83 bits.
    always_comb
    begin
        logic [82:0] m;
        m = 83'(phi_reg) + 83'((plo_reg + 58'd8388608) >> FracBitsL);
        mag = (m > 83'(limit)) ? limit : m[47:0];
    end

    assign prod_s = neg_reg ? 48'(-mag) : mag;
    assign sum = 50'(prod_s) + 50'(coef_reg);

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE: if (start) phase_next = PH_LO;
            PH_LO:   phase_next = PH_HI;
            PH_HI:   phase_next = PH_SUM;
            PH_SUM:  phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg <= (phase_reg == PH_SUM);
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && start)
        begin
            ma_reg <= ma_c;
            mb_reg <= mb_c;
            neg_reg <= (acc[47] != t[33]) && (acc != 48'sd0) && (t != 34'sd0);
            coef_reg <= coef;
        end
        if (phase_reg == PH_LO) plo_reg <= prod_c;
        if (phase_reg == PH_HI) phi_reg <= prod_c;
        if (phase_reg == PH_SUM) result_reg <= ppte_pkg::sat48(sum);
    end

    assign done = done_reg;
    assign result = result_reg;
endmodule
`default_nettype wire

// ===== sv/piecewise_poly_traj_eval.sv =====
// Writes are taken back to back while the block is idle; a query is taken only when idle
// and runs a walk over the pieces and then the Horner steps, or neither with no trajectory.
// The block runs one query at a time; each of the 21 Horner steps is a coefficient read, a
// start and the multiply-add, and the walk reads and compares each piece in turn.
// A finished result waits in the output register while later beats are taken; a query that
// ends while it is held stalls there. Reset clears piece count and control; lead = LEAD_RESET.
`default_nettype none
module piecewise_poly_traj_eval (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [27:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         kind,
    input  wire logic [4:0]         piece_index,
    input  wire logic [1:0]         axis,
    input  wire logic [2:0]         coef_index,
    input  wire logic signed [47:0] value,
    input  wire logic               is_final_piece,
    input  wire logic signed [31:0] query_time,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [47:0]      pos_x,
    output logic signed [47:0]      pos_y,
    output logic signed [47:0]      pos_z,
    output logic [4:0]              piece_used,
    output logic                    past_end,
    output logic                    no_trajectory
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WRD   = 4'd1;
    localparam logic [3:0] S_WCMP  = 4'd2;
    localparam logic [3:0] S_LAST  = 4'd3;
    localparam logic [3:0] S_C0RD  = 4'd4;
    localparam logic [3:0] S_C0    = 4'd5;
    localparam logic [3:0] S_CRD   = 4'd6;
    localparam logic [3:0] S_MSTART= 4'd7;
    localparam logic [3:0] S_MWAIT = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    localparam int PW = ppte_pkg::PieceW;
    localparam int CW = ppte_pkg::CountW;
    localparam int AW = ppte_pkg::CoefAddrW;

    logic signed [47:0] coef_mem [ppte_pkg::CoefDepth];
    logic [31:0]        dur_mem  [ppte_pkg::MaxPieces];

    logic [3:0]  state_reg;
    logic [CW-1:0] count_reg;
    logic [27:0] lead_reg;
    logic signed [33:0] t_reg;
    logic [PW-1:0] piece_reg;
    logic [1:0]  axis_reg;
    logic [2:0]  slot_reg;
    logic        past_reg;
    logic signed [47:0] acc_reg;
    logic signed [47:0] coef_rd_reg;
    logic [31:0] dur_rd_reg;
    logic signed [47:0] px_reg, py_reg, pz_reg;
    logic        ov_reg, nt_reg;
    logic signed [47:0] out_x_reg, out_y_reg, out_z_reg;
    logic [PW-1:0] out_piece_reg;
    logic        out_past_reg, out_nt_reg;

    logic [AW-1:0] caddr;
    logic        accept;
    logic        load_out;
    logic        mac_start, mac_done;
    logic signed [47:0] mac_res;
    logic [31:0] dur_sat;

    assign cfg_ready = (state_reg == S_IDLE) && !ov_reg;
    assign in_stall = (state_reg != S_IDLE);
    assign accept = in_valid && !in_stall;
    assign load_out = (state_reg == S_OUT) && (!ov_reg || !out_stall);

    always_comb
    begin
        if (value < 48'sd0) dur_sat = 32'd0;
        else if (value > 48'sd4294967295) dur_sat = 32'hFFFF_FFFF;
        else dur_sat = value[31:0];
    end

    assign caddr = ppte_pkg::coef_addr(piece_reg, axis_reg, slot_reg);

    // Memories: one write port (input beats), one registered read port each.
    always_ff @(posedge clk)
    begin
        if (accept && kind == ppte_pkg::KIND_COEF && axis != ppte_pkg::AXIS_NONE)
            coef_mem[ppte_pkg::coef_addr(piece_index, axis, coef_index)] <= value;
        if (accept && kind == ppte_pkg::KIND_DUR)
            dur_mem[piece_index] <= dur_sat;
        coef_rd_reg <= coef_mem[caddr];
        dur_rd_reg <= dur_mem[piece_reg];
    end

    assign mac_start = (state_reg == S_MSTART);

    ppte_mac u_mac (
        .clk(clk), .rst_n(rst_n), .start(mac_start), .acc(acc_reg),
        .t(t_reg), .coef(coef_rd_reg), .done(mac_done), .result(mac_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            lead_reg <= ppte_pkg::LEAD_RESET;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready) lead_reg <= cfg_data;
            if (load_out)
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && kind == ppte_pkg::KIND_DUR && is_final_piece)
                        count_reg <= CW'(piece_index) + CW'(1);
                    if (accept && kind == ppte_pkg::KIND_QUERY)
                    begin
                        t_reg <= 34'(query_time) + 34'(lead_reg);
                        piece_reg <= '0;
                        past_reg <= 1'b0;
                        nt_reg <= (count_reg == '0);
                        if (count_reg == '0)
                        begin
                            px_reg <= '0; py_reg <= '0; pz_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_WRD;
                    end
                end
                S_WRD: state_reg <= S_WCMP;
                S_WCMP:
                begin
                    if (t_reg <= $signed({2'b00, dur_rd_reg}))
                    begin
                        axis_reg <= ppte_pkg::AXIS_X; slot_reg <= 3'd0;
                        state_reg <= S_C0RD;
                    end
                    else if (CW'(piece_reg) + CW'(1) == count_reg)
                    begin
                        past_reg <= 1'b1;
                        t_reg <= $signed({2'b00, dur_rd_reg});
                        axis_reg <= ppte_pkg::AXIS_X; slot_reg <= 3'd0;
                        state_reg <= S_C0RD;
                    end
                    else
                    begin
                        t_reg <= t_reg - $signed({2'b00, dur_rd_reg});
                        piece_reg <= piece_reg + PW'(1);
                        state_reg <= S_WRD;
                    end
                end
                S_C0RD: state_reg <= S_C0;
                S_C0:
                begin
                    acc_reg <= coef_rd_reg;
                    slot_reg <= 3'd1;
                    state_reg <= S_CRD;
                end
                S_CRD: state_reg <= S_MSTART;
                S_MSTART: state_reg <= S_MWAIT;
                S_MWAIT:
                begin
                    if (mac_done)
                    begin
                        if (slot_reg == 3'(ppte_pkg::PolyOrder - 1))
                        begin
                            case (axis_reg)
                                ppte_pkg::AXIS_X: px_reg <= mac_res;
                                ppte_pkg::AXIS_Y: py_reg <= mac_res;
                                default: pz_reg <= mac_res;
                            endcase
                            if (axis_reg == ppte_pkg::AXIS_Z)
                                state_reg <= S_OUT;
                            else
                            begin
                                axis_reg <= axis_reg + 2'd1;
                                slot_reg <= 3'd0;
                                state_reg <= S_C0RD;
                            end
                        end
                        else
                        begin
                            acc_reg <= mac_res;
                            slot_reg <= slot_reg + 3'd1;
                            state_reg <= S_CRD;
                        end
                    end
                end
                S_OUT:
                begin
                    // Hold until the previous result beat has gone.
                    if (load_out)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_x_reg <= px_reg;
            out_y_reg <= py_reg;
            out_z_reg <= pz_reg;
            out_piece_reg <= piece_reg;
            out_past_reg <= past_reg;
            out_nt_reg <= nt_reg;
        end
    end

    assign out_valid = ov_reg;
    assign pos_x = out_x_reg;
    assign pos_y = out_y_reg;
    assign pos_z = out_z_reg;
    assign piece_used = 5'(out_piece_reg);
    assign past_end = out_past_reg;
    assign no_trajectory = out_nt_reg;
endmodule
`default_nettype wire

// ===== tb/sv/piecewise_poly_traj_eval_test.sv =====
// Self-checking testbench for the piecewise polynomial trajectory evaluator.
`default_nettype none
module piecewise_poly_traj_eval_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int TARGET_BEATS = 1200;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE = 300;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         piece;
        logic [1:0]         ax;
        logic [2:0]         slot;
        logic signed [47:0] val;
        logic               fin;
        logic signed [31:0] qt;
    } beat_t;

    typedef struct packed {
        logic signed [47:0] x;
        logic signed [47:0] y;
        logic signed [47:0] z;
        logic [4:0]         used;
        logic               past;
        logic               notraj;
    } pose_t;

    typedef struct packed {
        beat_t b;
        logic  typed;
        pose_t want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [27:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] kind = '0;
    logic [4:0] piece_index = '0;
    logic [1:0] axis = '0;
    logic [2:0] coef_index = '0;
    logic signed [47:0] value = '0;
    logic is_final_piece = 1'b0;
    logic signed [31:0] query_time = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [47:0] pos_x, pos_y, pos_z;
    logic [4:0] piece_used;
    logic past_end;
    logic no_trajectory;

    piecewise_poly_traj_eval dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .piece_index(piece_index), .axis(axis), .coef_index(coef_index),
        .value(value), .is_final_piece(is_final_piece), .query_time(query_time),
        .out_valid(out_valid), .out_stall(out_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .piece_used(piece_used), .past_end(past_end), .no_trajectory(no_trajectory)
    );

    always #6 clk = ~clk;

    // Predictor state
    longint      coef_mem [ppte_pkg::CoefDepth];
    logic [31:0] dur_mem [ppte_pkg::MaxPieces];
    bit          coef_seen [ppte_pkg::CoefDepth];
    bit          dur_seen [ppte_pkg::MaxPieces];
    int          traj_len = 0;
    logic [27:0] lead = ppte_pkg::LEAD_RESET;

    pose_t pose_q[$];
    row_t rows[$];
    int mismatches = 0;
    int beats_sent = 0;
    int poses_checked = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;

    function automatic longint clamp48(longint v);
        if (v > 64'sd140737488355327) return 64'sd140737488355327;
        if (v < -64'sd140737488355328) return -64'sd140737488355328;
        return v;
    endfunction

    // round(a*t / 2^24), ties away from zero, saturated to 48 bits
    function automatic longint mul_q24(longint a, longint t);
        logic neg;
        logic [63:0] ma, mt;
        logic [127:0] mag, lim;
        neg = (a < 0) != (t < 0);
        ma = (a < 0) ? 64'(-a) : 64'(a);
        mt = (t < 0) ? 64'(-t) : 64'(t);
        mag = ({64'd0, ma} * {64'd0, mt} + 128'd8388608) >> ppte_pkg::FracBits;
        lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
        if (mag > lim) mag = lim;
        return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    function automatic logic signed [47:0] horner(int p, int a, longint t);
        int base;
        longint acc;
        base = (p * ppte_pkg::Axes + a) * ppte_pkg::Slots;
        acc = coef_mem[base];
        for (int k = 1; k < ppte_pkg::PolyOrder; k++)
            acc = clamp48(mul_q24(acc, t) + coef_mem[base + k]);
        return acc[47:0];
    endfunction

    function automatic pose_t evaluate(logic signed [31:0] qt);
        pose_t r;
        longint t;
        int i;
        r = '0;
        if (traj_len == 0)
        begin
            r.notraj = 1'b1;
            return r;
        end
        t = longint'(qt) + longint'(lead);
        for (i = 0; i < traj_len; i++)
        begin
            if (t <= longint'(dur_mem[i])) break;
            t -= longint'(dur_mem[i]);
        end
        if (i >= traj_len)
        begin
            i = traj_len - 1;
            t = longint'(dur_mem[i]);
            r.past = 1'b1;
        end
        r.used = 5'(i);
        r.x = horner(i, 0, t);
        r.y = horner(i, 1, t);
        r.z = horner(i, 2, t);
        return r;
    endfunction

    function automatic bit prefix_loaded(int n);
        for (int p = 0; p < n; p++)
        begin
            if (!dur_seen[p]) return 0;
            for (int k = 0; k < ppte_pkg::Axes * ppte_pkg::Slots; k++)
                if (!coef_seen[p * ppte_pkg::Axes * ppte_pkg::Slots + k]) return 0;
        end
        return 1;
    endfunction

    // Update the predictor with one accepted beat.
    task automatic apply_beat(beat_t b, bit typed, pose_t want);
        int addr;
        case (b.kind)
            ppte_pkg::KIND_COEF:
            begin
                if (b.ax != ppte_pkg::AXIS_NONE)
                begin
                    addr = (int'(b.piece) * ppte_pkg::Axes + int'(b.ax)) * ppte_pkg::Slots
                           + int'(b.slot);
                    coef_mem[addr] = longint'(b.val);
                    coef_seen[addr] = 1'b1;
                end
            end
            ppte_pkg::KIND_DUR:
            begin
                if (b.val < 0) dur_mem[b.piece] = '0;
                else if (b.val > 48'sh0000_FFFF_FFFF) dur_mem[b.piece] = '1;
                else dur_mem[b.piece] = b.val[31:0];
                dur_seen[b.piece] = 1'b1;
                if (b.fin) traj_len = int'(b.piece) + 1;
            end
            ppte_pkg::KIND_QUERY: pose_q = {pose_q, (typed ? want : evaluate(b.qt))};
            default: ;
        endcase
    endtask

    // Drive one beat from the falling edge and return at the edge that takes it.
    task automatic send_beat(beat_t b, bit typed = 1'b0, pose_t want = '0);
        @(negedge clk);
        if (!quiet)
        begin
            while ($urandom_range(0, 99) < 31)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        end
        in_valid = 1'b1;
        kind = b.kind;
        piece_index = b.piece;
        axis = b.ax;
        coef_index = b.slot;
        value = b.val;
        is_final_piece = b.fin;
        query_time = b.qt;
        do @(posedge clk); while (in_stall);
        apply_beat(b, typed, want);
        if (b.kind != KIND_SPARE
            && !(b.kind == ppte_pkg::KIND_COEF && b.ax == ppte_pkg::AXIS_NONE))
            beats_sent++;
    endtask

    task automatic idle_input();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain_and_settle();
        idle_input();
        while (pose_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_lead(logic [27:0] v);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = v;
        do @(posedge clk); while (!cfg_ready);
        lead = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic signed [47:0] pick_coef();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return ppte_pkg::MAX48;
        if (r < 10) return ppte_pkg::MIN48;
        if (r < 20) return 48'({$urandom, $urandom});
        return 48'(longint'($signed($urandom)) >>> $urandom_range(2, 12));
    endfunction

    function automatic beat_t noise_beat();
        beat_t b;
        b = '0;
        b.kind = 2'($urandom_range(0, 3));
        b.piece = 5'($urandom);
        b.ax = 2'($urandom);
        b.slot = 3'($urandom);
        b.val = 48'({$urandom, $urandom});
        b.qt = $urandom;
        b.fin = 1'($urandom_range(0, 1));
        if (b.kind == ppte_pkg::KIND_DUR && b.fin && !prefix_loaded(int'(b.piece) + 1))
            b.fin = 1'b0;
        if (b.kind == ppte_pkg::KIND_QUERY && !prefix_loaded(traj_len))
            b.kind = KIND_SPARE;
        return b;
    endfunction

    task automatic load_and_query(int n, int queries);
        beat_t b;
        longint total;
        total = 0;
        for (int p = 0; p < n; p++)
        begin
            for (int a = 0; a < ppte_pkg::Axes; a++)
            begin
                for (int s = 0; s < ppte_pkg::Slots; s++)
                begin
                    b = '0;
                    b.kind = ppte_pkg::KIND_COEF;
                    b.piece = 5'(p);
                    b.ax = 2'(a);
                    b.slot = 3'(s);
                    b.val = pick_coef();
                    b.qt = $urandom;
                    send_beat(b);
                end
            end
            b = '0;
            b.kind = ppte_pkg::KIND_DUR;
            b.piece = 5'(p);
            b.val = ($urandom_range(0, 19) == 0) ? 48'({$urandom, $urandom})
                                               : 48'($urandom_range(1 << 20, 1 << 26));
            b.fin = (p == n - 1);
            b.qt = $urandom;
            send_beat(b);
            total += longint'(dur_mem[p]);
        end
        for (int q = 0; q < queries; q++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_beat(noise_beat());
                continue;
            end
            b = '0;
            b.kind = ppte_pkg::KIND_QUERY;
            b.piece = 5'($urandom);
            b.val = 48'({$urandom, $urandom});
            case ($urandom_range(0, 4))
                0: b.qt = $urandom;
                1: b.qt = -$signed(32'($urandom_range(0, 1 << 26)));
                default:
                    b.qt = 32'(longint'($urandom_range(0, 32'(total + 2))) - longint'(lead));
            endcase
            send_beat(b);
        end
    endtask

    function automatic row_t mk(logic [1:0] k, logic [4:0] p, logic [1:0] a, logic [2:0] s,
                                logic signed [47:0] v, logic f, logic signed [31:0] qt,
                                logic typed);
        row_t r;
        r = '0;
        r.b = '{k, p, a, s, v, f, qt};
        r.typed = typed;
        r.want.notraj = typed;
        return r;
    endfunction

    // Directed opening: empty trajectory, ignored beats and saturating durations
    initial
    begin
        rows = {rows, mk(ppte_pkg::KIND_QUERY, 5'd0, 2'd0, 3'd0, 48'sd0, 1'b0, 32'sd0, 1'b1)};
        rows = {rows, mk(ppte_pkg::KIND_QUERY, 5'd31, 2'd3, 3'd7, ppte_pkg::MAX48, 1'b1,
                         32'h7FFF_FFFF, 1'b1)};
        rows = {rows, mk(ppte_pkg::KIND_QUERY, 5'd0, 2'd0, 3'd0, ppte_pkg::MIN48, 1'b0,
                         32'h8000_0000, 1'b1)};
        rows = {rows, mk(KIND_SPARE, 5'd31, 2'd3, 3'd7, ppte_pkg::MAX48, 1'b1,
                         32'hFFFF_FFFF, 1'b0)};
        rows = {rows, mk(ppte_pkg::KIND_COEF, 5'd31, ppte_pkg::AXIS_NONE, 3'd7,
                         ppte_pkg::MAX48, 1'b0, 32'sd0, 1'b0)};
        rows = {rows, mk(ppte_pkg::KIND_DUR, 5'd0, 2'd0, 3'd0, ppte_pkg::MIN48, 1'b0,
                         32'sd0, 1'b0)};
        rows = {rows, mk(ppte_pkg::KIND_DUR, 5'd31, 2'd0, 3'd0, ppte_pkg::MAX48, 1'b0,
                         32'sd0, 1'b0)};
        rows = {rows, mk(ppte_pkg::KIND_COEF, 5'd31, ppte_pkg::AXIS_Z, 3'd7,
                         ppte_pkg::MIN48, 1'b0, 32'sd0, 1'b0)};
        rows = {rows, mk(ppte_pkg::KIND_COEF, 5'd0, ppte_pkg::AXIS_X, 3'd0,
                         ppte_pkg::MAX48, 1'b0, 32'sd0, 1'b0)};
        rows = {rows, mk(ppte_pkg::KIND_QUERY, 5'd0, 2'd0, 3'd0, 48'sd0, 1'b0, -32'sd1, 1'b1)};
    end

    always
    begin
        @(negedge clk);
        if (hold_req)
        begin
            hold_req = 1'b0;
            out_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
        end
        out_stall = quiet ? 1'b0 : ($urandom_range(0, 99) < 31);
    end

    always @(posedge clk)
    begin
        pose_t got;
        pose_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{pos_x, pos_y, pos_z, piece_used, past_end, no_trajectory};
            if (pose_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", got);
            end
            else
            begin
                want = pose_q.pop_front();
                poses_checked++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timed out with %0d results outstanding", pose_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [27:0] leads[4];
        for (int i = 0; i < ppte_pkg::MaxPieces; i++) dur_mem[i] = '0;
        for (int i = 0; i < ppte_pkg::CoefDepth; i++) coef_mem[i] = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i]) send_beat(rows[i].b, rows[i].typed, rows[i].want);
        drain_and_settle();

        leads = '{28'd0, 28'hFFF_FFFF, 28'($urandom), ppte_pkg::LEAD_RESET};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_lead(leads[ph]);
            quiet = (ph == 1);
            if (ph == 2)
            begin
                // Back up the output while queries keep arriving.
                load_and_query(1, 0);
                hold_req = 1'b1;
                load_and_query(0, 12);
            end
            while (beats_sent < TARGET_BEATS * (ph + 1) / 4)
                load_and_query(($urandom_range(0, 9) == 0) ? $urandom_range(5, 12)
                                                          : $urandom_range(1, 4),
                               $urandom_range(8, 20));
            quiet = 1'b0;
            drain_and_settle();
        end

        $display("%0d beats sent, %0d results checked over four lead-time settings",
                 beats_sent, poses_checked);
        if (mismatches == 0 && pose_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// ===== piecewise_poly_traj_eval.f =====
sv/ppte_pkg.sv
sv/ppte_mac.sv
sv/piecewise_poly_traj_eval.sv
tb/sv/piecewise_poly_traj_eval_test.sv
